// File: src/tdsb_pkg.sv
// Package for the two-row display scroll and backlight sequencer.
// Holds item types, command and effect codes, and the backlight tables.
// No dependencies.
`timescale 1ns / 1ps

package tdsb_pkg;

    localparam int unsigned ROW_LEN_DEF       = 40;
    localparam int unsigned VISIBLE_COLS_DEF  = 16;
    localparam int unsigned SCROLL_PAUSE_DEF  = 8;
    localparam int unsigned HOME_PAUSE_DEF    = 8;
    localparam int unsigned SLEEP_TICKS_DEF   = 3000;

    localparam int unsigned LEN_W     = 7;
    localparam int unsigned POS_W     = 6;
    localparam int unsigned PAUSE_W   = 4;
    localparam int unsigned SLEEP_W   = 12;
    localparam int unsigned STEP_W    = 7;
    localparam int unsigned DUTY_W    = 11;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 4;

    localparam logic [STEP_W-1:0] PULSE_LAST   = 7'd71;
    localparam logic [STEP_W-1:0] PULSE_HALF   = 7'd36;
    localparam logic [STEP_W-1:0] PULSE_QUART  = 7'd18;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_REDRAW = 2'd1,
        CMD_HOME   = 2'd2,
        CMD_BACK   = 2'd3
    } t_cmd;

    localparam logic [2:0] EFF_DEFAULT    = 3'd0;
    localparam logic [2:0] EFF_TO_START   = 3'd1;
    localparam logic [2:0] EFF_WRAP_SPACE = 3'd2;
    localparam logic [2:0] EFF_WRAP       = 3'd3;
    localparam logic [2:0] EFF_REVERSE    = 3'd4;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_EFFECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL  = 2'd2;

    typedef struct packed {
        logic       operation;
        logic       row;
        logic [5:0] text_length;
    } t_in_item;

    typedef struct packed {
        t_cmd        command;
        logic [5:0]  forward_shifts;
        logic [5:0]  position;
        logic [10:0] backlight_duty;
    } t_out_item;

    // What the scroll unit tells the rest of the block about one tick.
    typedef struct packed {
        t_cmd             command;
        logic [5:0]       shifts;
        logic [POS_W-1:0] position;
        logic             redraw;
    } t_scroll_res;

    // round(1024 * max(0.05, 0.8 * sin(5q degrees))) for q = 0..18.
    function automatic logic [DUTY_W-1:0] quarter_wave(input logic [4:0] q);
        logic [DUTY_W-1:0] d;
        unique case (q)
            5'd0:    d = 11'd51;
            5'd1:    d = 11'd71;
            5'd2:    d = 11'd142;
            5'd3:    d = 11'd212;
            5'd4:    d = 11'd280;
            5'd5:    d = 11'd346;
            5'd6:    d = 11'd410;
            5'd7:    d = 11'd470;
            5'd8:    d = 11'd527;
            5'd9:    d = 11'd579;
            5'd10:   d = 11'd628;
            5'd11:   d = 11'd671;
            5'd12:   d = 11'd709;
            5'd13:   d = 11'd742;
            5'd14:   d = 11'd770;
            5'd15:   d = 11'd791;
            5'd16:   d = 11'd807;
            5'd17:   d = 11'd816;
            5'd18:   d = 11'd819;
            default: d = 11'd0;
        endcase
        return d;
    endfunction

    // Steady level in tenths, rounded to 1024ths; ten and above is full scale.
    function automatic logic [DUTY_W-1:0] steady_duty(input logic [3:0] level);
        logic [DUTY_W-1:0] d;
        unique case (level)
            4'd0:    d = 11'd0;
            4'd1:    d = 11'd102;
            4'd2:    d = 11'd205;
            4'd3:    d = 11'd307;
            4'd4:    d = 11'd410;
            4'd5:    d = 11'd512;
            4'd6:    d = 11'd614;
            4'd7:    d = 11'd717;
            4'd8:    d = 11'd819;
            4'd9:    d = 11'd922;
            default: d = 11'd1024;
        endcase
        return d;
    endfunction

endpackage

// File: src/tdsb_scroll.sv
// Scroll unit: row lengths, redraw and scroll state, one item per cycle while i_go is high.
// Depends on tdsb_pkg.
`timescale 1ns / 1ps

module tdsb_scroll #(
    parameter int unsigned ROW_LEN            = tdsb_pkg::ROW_LEN_DEF,
    parameter int unsigned VISIBLE_COLS       = tdsb_pkg::VISIBLE_COLS_DEF,
    parameter int unsigned SCROLL_PAUSE_TICKS = tdsb_pkg::SCROLL_PAUSE_DEF,
    parameter int unsigned HOME_PAUSE_TICKS   = tdsb_pkg::HOME_PAUSE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  tdsb_pkg::t_in_item    i_item,
    input  logic [2:0]            i_effect,
    output tdsb_pkg::t_scroll_res o_res
);
    import tdsb_pkg::*;

    localparam logic [LEN_W-1:0]   L_ROW    = LEN_W'(ROW_LEN);
    localparam logic [LEN_W-1:0]   L_ROW_M1 = LEN_W'(ROW_LEN - 1);
    localparam logic [LEN_W-1:0]   L_VIS    = LEN_W'(VISIBLE_COLS);
    localparam logic [LEN_W-1:0]   L_SPAN   = LEN_W'(ROW_LEN - VISIBLE_COLS);
    localparam logic [LEN_W-1:0]   L_SKIP   = LEN_W'(ROW_LEN - VISIBLE_COLS + 1);
    localparam logic [POS_W-1:0]   L_LAST   = POS_W'(ROW_LEN - 1);
    localparam logic [PAUSE_W-1:0] L_SPAUSE = PAUSE_W'(SCROLL_PAUSE_TICKS);
    localparam logic [PAUSE_W-1:0] L_HPAUSE = PAUSE_W'(HOME_PAUSE_TICKS);

    logic [LEN_W-1:0]   r_len [2];
    logic [LEN_W-1:0]   n_len [2];
    logic [LEN_W-1:0]   r_longest, n_longest;
    logic               r_pending, n_pending;
    logic [PAUSE_W-1:0] r_spause, n_spause;
    logic [PAUSE_W-1:0] r_hpause, n_hpause;
    logic               r_fwd, n_fwd;
    logic [POS_W-1:0]   r_pos, n_pos;

    logic [LEN_W-1:0] s_clip, s_pad0, s_pad1, s_pos_ext, s_end, s_shifts, s_sum;
    logic [POS_W-1:0] s_back;
    t_cmd             s_cmd;

    assign s_pos_ext = {1'b0, r_pos};

    always_comb begin
        n_len     = r_len;
        n_longest = r_longest;
        n_pending = r_pending;
        n_spause  = r_spause;
        n_hpause  = r_hpause;
        n_fwd     = r_fwd;
        n_pos     = r_pos;
        s_cmd     = CMD_NONE;
        s_shifts  = '0;
        s_end     = r_longest - L_VIS;
        s_sum     = s_pos_ext + s_shifts;
        s_back    = (r_pos == '0) ? L_LAST : r_pos - 1'b1;
        s_clip    = ({1'b0, i_item.text_length} > L_ROW) ? L_ROW
                                                         : {1'b0, i_item.text_length};
        s_pad0    = (i_effect == EFF_WRAP_SPACE && r_len[0] == L_ROW_M1) ? L_ROW : r_len[0];
        s_pad1    = (i_effect == EFF_WRAP_SPACE && r_len[1] == L_ROW_M1) ? L_ROW : r_len[1];

        if (i_item.operation == OP_WRITE) begin
            n_len[i_item.row] = s_clip;
            n_pending         = 1'b1;
        end else if (r_pending) begin
            n_len[0]  = s_pad0;
            n_len[1]  = s_pad1;
            n_longest = (s_pad0 > s_pad1) ? s_pad0 : s_pad1;
            n_pos     = '0;
            n_spause  = '0;
            n_pending = 1'b0;
            n_fwd     = 1'b1;
            s_cmd     = CMD_REDRAW;
        end else if (r_longest > L_VIS) begin
            if (r_spause < L_SPAUSE) begin
                n_spause = r_spause + 1'b1;
            end else if (i_effect <= EFF_TO_START) begin
                if (s_pos_ext >= s_end) begin
                    if (r_hpause < L_HPAUSE) begin
                        n_hpause = r_hpause + 1'b1;
                    end else begin
                        s_cmd    = CMD_HOME;
                        n_pos    = '0;
                        n_spause = '0;
                        n_hpause = '0;
                    end
                end else begin
                    s_shifts = LEN_W'(1);
                end
            end else if (i_effect <= EFF_WRAP) begin
                // Past the text in the blank tail: jump straight to ROW_LEN - VISIBLE_COLS + 1.
                if (s_pos_ext > r_longest && s_pos_ext < L_SPAN) begin
                    s_shifts = L_SKIP - s_pos_ext;
                end else begin
                    s_shifts = LEN_W'(1);
                end
            end else if (i_effect == EFF_REVERSE) begin
                if (r_fwd) begin
                    if (s_pos_ext >= s_end) begin
                        n_fwd = 1'b0;
                    end else begin
                        s_shifts = LEN_W'(1);
                    end
                end else begin
                    s_cmd = CMD_BACK;
                    n_pos = s_back;
                    if (s_back == '0) begin
                        n_fwd = 1'b1;
                    end
                end
            end
            if (s_shifts != '0) begin
                s_sum = s_pos_ext + s_shifts;
                n_pos = (s_sum >= L_ROW) ? POS_W'(s_sum - L_ROW) : POS_W'(s_sum);
            end
        end
    end

    assign o_res.command  = s_cmd;
    assign o_res.shifts   = s_shifts[5:0];
    assign o_res.position = n_pos;
    assign o_res.redraw   = (s_cmd == CMD_REDRAW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len[0]  <= '0;
            r_len[1]  <= '0;
            r_longest <= '0;
            r_pending <= 1'b0;
            r_spause  <= '0;
            r_hpause  <= '0;
            r_fwd     <= 1'b1;
            r_pos     <= '0;
        end else if (i_go) begin
            r_len     <= n_len;
            r_longest <= n_longest;
            r_pending <= n_pending;
            r_spause  <= n_spause;
            r_hpause  <= n_hpause;
            r_fwd     <= n_fwd;
            r_pos     <= n_pos;
        end
    end

    a_pos_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_pos_ext < L_ROW)
        else $error("scroll position left the row");

    a_redraw_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_res.redraw) |=> (!r_pending && r_spause == '0 && r_pos == '0))
        else $error("redraw did not restart scrolling");

endmodule

// File: src/tdsb_backlight.sv
// Backlight unit: pulse angle, sleep timer and the duty of each tick.
// Depends on tdsb_pkg for the duty tables.
`timescale 1ns / 1ps

module tdsb_backlight #(
    parameter int unsigned SLEEP_TICKS = tdsb_pkg::SLEEP_TICKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tick,
    input  logic                        i_redraw,
    input  logic                        i_pulse,
    input  logic [3:0]                  i_level,
    output logic [tdsb_pkg::DUTY_W-1:0] o_duty
);
    import tdsb_pkg::*;

    logic [STEP_W-1:0]  r_step, n_step;
    logic [SLEEP_W-1:0] r_sleep, n_sleep;
    logic [SLEEP_W-1:0] s_sleep;
    logic [STEP_W-1:0]  s_half, s_quart;

    // A redraw reloads the timer before this tick's duty is worked out.
    assign s_sleep = i_redraw ? SLEEP_W'(SLEEP_TICKS) : r_sleep;
    assign s_half  = (r_step >= PULSE_HALF) ? r_step - PULSE_HALF : r_step;
    assign s_quart = (s_half <= PULSE_QUART) ? s_half : PULSE_HALF - s_half;

    always_comb begin
        n_step  = r_step;
        n_sleep = s_sleep;
        o_duty  = '0;
        if (i_pulse) begin
            o_duty = quarter_wave(s_quart[4:0]);
            n_step = (r_step == PULSE_LAST) ? '0 : r_step + 1'b1;
        end else begin
            n_step = '0;
            if (s_sleep != '0) begin
                n_sleep = s_sleep - 1'b1;
                o_duty  = steady_duty(i_level);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_sleep <= '0;
        end else if (i_tick) begin
            r_step  <= n_step;
            r_sleep <= n_sleep;
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= PULSE_LAST)
        else $error("pulse step out of range");

endmodule

// File: src/text_display_scroll_backlight_sequencer_unit.sv
// Top level of the display scroll and backlight sequencer.
// Depends on tdsb_pkg, tdsb_scroll and tdsb_backlight.
//
//   channel  signals                              direction  item
//   in       i_in_valid / o_in_ready / i_in_item  to block   t_in_item
//   out      o_out_valid / i_out_ready / o_out_item from block t_out_item
//   cfg      i_cfg_valid / o_cfg_ready / index, data to block register write
//
// An item is taken into the input register, worked on once the output
// register is free, and its result lands in the output register.
// Unless the output stalls, one item per cycle; a text write gives no result.
// A stalled output holds the result and stops the input register only when
// the input register is also full. Reset restores all state but the item registers.
`timescale 1ns / 1ps

module text_display_scroll_backlight_sequencer_unit #(
    parameter int unsigned ROW_LEN            = tdsb_pkg::ROW_LEN_DEF,
    parameter int unsigned VISIBLE_COLS       = tdsb_pkg::VISIBLE_COLS_DEF,
    parameter int unsigned SCROLL_PAUSE_TICKS = tdsb_pkg::SCROLL_PAUSE_DEF,
    parameter int unsigned HOME_PAUSE_TICKS   = tdsb_pkg::HOME_PAUSE_DEF,
    parameter int unsigned SLEEP_TICKS        = tdsb_pkg::SLEEP_TICKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  tdsb_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output tdsb_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tdsb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tdsb_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import tdsb_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [2:0]  r_effect;
    logic        r_pulse;
    logic [3:0]  r_level;

    logic              s_out_free, s_go, s_tick;
    t_scroll_res       s_res;
    logic [DUTY_W-1:0] s_duty;

    assign s_out_free  = !r_out_valid || i_out_ready;
    assign s_go        = r_in_valid && s_out_free;
    assign s_tick      = s_go && (r_in.operation == OP_TICK);
    assign o_in_ready  = !r_in_valid || s_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    tdsb_scroll #(
        .ROW_LEN            (ROW_LEN),
        .VISIBLE_COLS       (VISIBLE_COLS),
        .SCROLL_PAUSE_TICKS (SCROLL_PAUSE_TICKS),
        .HOME_PAUSE_TICKS   (HOME_PAUSE_TICKS)
    ) u_scroll (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (s_go),
        .i_item   (r_in),
        .i_effect (r_effect),
        .o_res    (s_res)
    );

    tdsb_backlight #(
        .SLEEP_TICKS (SLEEP_TICKS)
    ) u_backlight (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (s_tick),
        .i_redraw (s_res.redraw),
        .i_pulse  (r_pulse),
        .i_level  (r_level),
        .o_duty   (s_duty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (s_go) begin
                r_in_valid <= 1'b0;
            end
            if (s_tick) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (s_tick) begin
            r_out.command        <= s_res.command;
            r_out.forward_shifts <= s_res.shifts;
            r_out.position       <= s_res.position;
            r_out.backlight_duty <= s_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect <= EFF_REVERSE;
            r_pulse  <= 1'b0;
            r_level  <= 4'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_EFFECT: r_effect <= i_cfg_data[2:0];
                CFG_PULSE:  r_pulse  <= i_cfg_data[0];
                CFG_LEVEL:  r_level  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_go && r_in.operation == OP_WRITE) |=> !r_out_valid)
        else $error("text write produced a result");

    a_shift_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.forward_shifts != '0) |-> (r_out.command == CMD_NONE))
        else $error("forward shifts issued together with a command");

endmodule

// File: tb/text_display_scroll_backlight_sequencer_unit_test.sv
// Self-checking testbench for the display scroll and backlight sequencer.
// Drives text writes, refresh ticks and register writes with random idling on the
// input and output channels and checks every tick report against a predictor or the scripted opening.
// Depends on tdsb_pkg and text_display_scroll_backlight_sequencer_unit.
`timescale 1ns / 1ps

module text_display_scroll_backlight_sequencer_unit_test;

    import tdsb_pkg::*;

    localparam int unsigned ROW_LEN            = ROW_LEN_DEF;
    localparam int unsigned VISIBLE_COLS       = VISIBLE_COLS_DEF;
    localparam int unsigned WAIT_BEFORE_SCROLL = SCROLL_PAUSE_DEF;
    localparam int unsigned HOME_PAUSE         = HOME_PAUSE_DEF;
    localparam int unsigned SLEEP_TICKS        = SLEEP_TICKS_DEF;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 12;
    localparam int MAX_WAIT      = 17;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int MAX_NOTES     = 100;
    localparam int OPENING_ROWS  = 25;
    localparam int PRESETS       = 9;
    localparam int PRESSURE_PHASE = 4;
    localparam int CLOSING_TICKS = 40;

    // Register index with no register behind it, and effect codes with no scroll.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [2:0] EFF_NONE_LO = 3'd5;
    localparam logic [2:0] EFF_NONE_HI = 3'd7;

    localparam t_out_item NO_REPORT = '0;

    typedef struct packed {
        logic      typed;
        t_in_item  item;
        t_out_item res;
    } t_script_row;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_item             in_item   = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out_item            o_out_item;
    logic                 o_cfg_ready;

    text_display_scroll_backlight_sequencer_unit #(
        .ROW_LEN            (ROW_LEN),
        .VISIBLE_COLS       (VISIBLE_COLS),
        .SCROLL_PAUSE_TICKS (WAIT_BEFORE_SCROLL),
        .HOME_PAUSE_TICKS   (HOME_PAUSE),
        .SLEEP_TICKS        (SLEEP_TICKS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Register and display state as the block should hold it.
    logic [2:0]  eff_sel      = EFF_REVERSE;
    logic        pulse_on     = 1'b0;
    logic [3:0]  level_tenths = 4'd2;
    logic [5:0]  scroll_pos   = '0;
    logic [5:0]  row_len [2]  = '{6'd0, 6'd0};
    logic [5:0]  longest      = '0;
    logic        pending      = 1'b0;
    logic [3:0]  scroll_wait  = '0;
    logic [3:0]  home_wait    = '0;
    logic        forward      = 1'b1;
    logic [6:0]  wave_step    = '0;
    logic [11:0] sleep_left   = '0;
    t_cmd        last_cmd     = CMD_NONE;

    // Quarter of the pulse wave in 5 degree steps, rounded and scaled.
    int quarter_sine [19] = '{51, 71, 142, 212, 280, 346, 410, 470, 527, 579,
                              628, 671, 709, 742, 770, 791, 807, 816, 819};

    t_out_item tick_reports_due [$];
    int        input_items     = 0;
    int        reports_checked = 0;
    int        failures        = 0;
    int        send_calm       = 0;
    int        sink_calm       = 0;
    logic      hold_pending    = 1'b0;

    // Directed opening under the reset settings: reverse effect, steady level 2.
    t_script_row opening [OPENING_ROWS] = '{
        {1'b1, OP_TICK,  1'b1, 6'd63, CMD_NONE,   6'd0, 6'd0, 11'd0},
        {1'b0, OP_WRITE, 1'b0, 6'd63, NO_REPORT},
        {1'b0, OP_WRITE, 1'b1, 6'd0,  NO_REPORT},
        {1'b1, OP_TICK,  1'b0, 6'd0,  CMD_REDRAW, 6'd0, 6'd0, 11'd205},
        {1'b0, OP_WRITE, 1'b1, 6'd41, NO_REPORT},
        {1'b0, OP_WRITE, 1'b0, 6'd16, NO_REPORT},
        {1'b1, OP_TICK,  1'b1, 6'd42, CMD_REDRAW, 6'd0, 6'd0, 11'd205},
        {1'b0, OP_TICK,  1'b0, 6'd21, NO_REPORT},
        {1'b0, OP_TICK,  1'b1, 6'd0,  NO_REPORT},
        {1'b0, OP_TICK,  1'b0, 6'd63, NO_REPORT},
        {1'b0, OP_TICK,  1'b1, 6'd5,  NO_REPORT},
        {1'b0, OP_TICK,  1'b0, 6'd0,  NO_REPORT},
        {1'b0, OP_TICK,  1'b0, 6'd0,  NO_REPORT},
        {1'b0, OP_TICK,  1'b1, 6'd9,  NO_REPORT},
        {1'b0, OP_TICK,  1'b0, 6'd0,  NO_REPORT},
        {1'b0, OP_TICK,  1'b0, 6'd0,  NO_REPORT},
        {1'b0, OP_TICK,  1'b1, 6'd30, NO_REPORT},
        {1'b0, OP_WRITE, 1'b0, 6'd17, NO_REPORT},
        {1'b0, OP_WRITE, 1'b1, 6'd39, NO_REPORT},
        {1'b1, OP_TICK,  1'b0, 6'd0,  CMD_REDRAW, 6'd0, 6'd0, 11'd205},
        {1'b0, OP_TICK,  1'b0, 6'd0,  NO_REPORT},
        {1'b0, OP_WRITE, 1'b0, 6'd1,  NO_REPORT},
        {1'b0, OP_WRITE, 1'b1, 6'd0,  NO_REPORT},
        {1'b1, OP_TICK,  1'b0, 6'd0,  CMD_REDRAW, 6'd0, 6'd0, 11'd205},
        {1'b1, OP_TICK,  1'b0, 6'd0,  CMD_NONE,   6'd0, 6'd0, 11'd205}
    };

    // Effect, pulse and level for the first phases, extremes among them.
    logic [7:0] presets [PRESETS] = '{
        {EFF_DEFAULT,    1'b0, 4'd10},
        {EFF_TO_START,   1'b0, 4'd0},
        {EFF_WRAP_SPACE, 1'b1, 4'd15},
        {EFF_WRAP,       1'b0, 4'd11},
        {EFF_REVERSE,    1'b1, 4'd5},
        {EFF_NONE_LO,    1'b0, 4'd1},
        {EFF_NONE_HI,    1'b1, 4'd3},
        {EFF_WRAP_SPACE, 1'b0, 4'd7},
        {EFF_DEFAULT,    1'b1, 4'd9}
    };

    // Applies one item to the predicted state; returns 1 when a tick report is due.
    function automatic bit advance_display(input t_in_item it, output t_out_item res);
        logic [5:0] len;
        int         shifts;
        int         end_pos;
        int         fold;
        int         duty;
        t_cmd       cmd;
        res = '0;
        if (it.operation == OP_WRITE) begin
            len = (it.text_length > ROW_LEN) ? 6'(ROW_LEN) : it.text_length;
            row_len[it.row] = len;
            pending = 1'b1;
            return 1'b0;
        end
        cmd = CMD_NONE;
        shifts = 0;
        if (pending) begin
            for (int r = 0; r < 2; r++) begin
                if (eff_sel == EFF_WRAP_SPACE && row_len[r] == ROW_LEN - 1)
                    row_len[r] = 6'(ROW_LEN);
            end
            longest = (row_len[0] > row_len[1]) ? row_len[0] : row_len[1];
            scroll_pos = '0;
            scroll_wait = '0;
            pending = 1'b0;
            forward = 1'b1;
            sleep_left = 12'(SLEEP_TICKS);
            cmd = CMD_REDRAW;
        end else if (longest > VISIBLE_COLS) begin
            end_pos = longest - VISIBLE_COLS;
            if (scroll_wait < WAIT_BEFORE_SCROLL) begin
                scroll_wait++;
            end else if (eff_sel <= EFF_TO_START) begin
                if (scroll_pos >= end_pos) begin
                    if (home_wait < HOME_PAUSE) begin
                        home_wait++;
                    end else begin
                        cmd = CMD_HOME;
                        scroll_pos = '0;
                        scroll_wait = '0;
                        home_wait = '0;
                    end
                end else begin
                    shifts = 1;
                end
            end else if (eff_sel <= EFF_WRAP) begin
                // Blank space past the text is skipped in one jump.
                if (scroll_pos > longest && scroll_pos < ROW_LEN - VISIBLE_COLS)
                    shifts = ROW_LEN - VISIBLE_COLS + 1 - scroll_pos;
                else
                    shifts = 1;
            end else if (eff_sel == EFF_REVERSE) begin
                if (forward) begin
                    if (scroll_pos >= end_pos)
                        forward = 1'b0;
                    else
                        shifts = 1;
                end else begin
                    cmd = CMD_BACK;
                    scroll_pos = (scroll_pos == 0) ? 6'(ROW_LEN - 1) : scroll_pos - 6'd1;
                    if (scroll_pos == 0)
                        forward = 1'b1;
                end
            end
            if (shifts != 0)
                scroll_pos = 6'((scroll_pos + shifts) % ROW_LEN);
        end
        if (pulse_on) begin
            fold = wave_step % 36;
            if (fold > 18)
                fold = 36 - fold;
            duty = quarter_sine[fold];
            wave_step = (wave_step == 7'd71) ? 7'd0 : wave_step + 7'd1;
        end else begin
            wave_step = '0;
            if (sleep_left != 0) begin
                sleep_left--;
                duty = (level_tenths >= 10) ? 1024 : (level_tenths * 1024 + 5) / 10;
            end else begin
                duty = 0;
            end
        end
        last_cmd = cmd;
        res.command = cmd;
        res.forward_shifts = 6'(shifts);
        res.position = scroll_pos;
        res.backlight_duty = 11'(duty);
        return 1'b1;
    endfunction

    // Cycles to wait before the next item; now and then a calm stretch with none.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [5:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 6'd0;
            1:       return 6'($urandom_range(VISIBLE_COLS - 1, VISIBLE_COLS + 1));
            2:       return 6'(ROW_LEN - 1);
            3:       return 6'(ROW_LEN);
            4:       return 6'($urandom_range(ROW_LEN + 1, 63));
            5, 6:    return 6'($urandom_range(VISIBLE_COLS + 1, ROW_LEN - VISIBLE_COLS));
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            failures++;
            if (failures <= MAX_NOTES)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    task automatic push_item(input t_in_item it, input logic typed, input t_out_item typed_res);
        t_out_item res;
        int        gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_item <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!o_in_ready);
        input_items++;
        if (advance_display(it, res))
            tick_reports_due.push_back(typed ? typed_res : res);
    endtask

    task automatic push_tick();
        push_item({OP_TICK, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63))},
                  1'b0, NO_REPORT);
    endtask

    task automatic push_write(input logic row, input logic [5:0] len);
        push_item({OP_WRITE, row, len}, 1'b0, NO_REPORT);
    endtask

    // Registers change only once every report is in and the block has gone quiet.
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DAT_W-1:0] data);
        in_valid <= 1'b0;
        while (tick_reports_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_EFFECT: eff_sel = data[2:0];
            CFG_PULSE:  pulse_on = data[0];
            CFG_LEVEL:  level_tenths = data;
            default:    ;
        endcase
    endtask

    // Leaves reverse mode turned round, returns home under the back-to-start
    // effect, then reverses again so that the back shift starts from position zero.
    task automatic chase_back_from_zero();
        int guard;
        write_setting(CFG_EFFECT, {1'b0, EFF_REVERSE});
        push_write(1'b0, 6'(VISIBLE_COLS + 1));
        push_write(1'b1, 6'($urandom_range(0, VISIBLE_COLS + 1)));
        guard = 0;
        do begin
            push_tick();
            guard++;
        end while (forward && guard < 80);
        write_setting(CFG_EFFECT, {1'b0, EFF_TO_START});
        guard = 0;
        do begin
            push_tick();
            guard++;
        end while (last_cmd != CMD_HOME && guard < 80);
        write_setting(CFG_EFFECT, {1'b0, EFF_REVERSE});
        repeat (60) push_tick();
    endtask

    always @(posedge clk) begin : report_check
        t_out_item want;
        if (rst_n && o_out_valid && out_ready) begin
            if (tick_reports_due.size() == 0) begin
                failures++;
                if (failures <= MAX_NOTES)
                    $display("%0t: report with none expected, got cmd %0d shifts %0d pos %0d duty %0d",
                             $time, o_out_item.command, o_out_item.forward_shifts,
                             o_out_item.position, o_out_item.backlight_duty);
            end else begin
                want = tick_reports_due.pop_front();
                reports_checked++;
                check_field("command", want.command, o_out_item.command);
                check_field("forward_shifts", want.forward_shifts, o_out_item.forward_shifts);
                check_field("position", want.position, o_out_item.position);
                check_field("backlight_duty", want.backlight_duty, o_out_item.backlight_duty);
            end
        end
    end

    // Receiver: a random stall before each item, and one long hold-off on request.
    initial begin : report_sink
        int stall;
        forever begin
            stall = draw_wait(sink_calm);
            if (hold_pending) begin
                stall = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!o_out_valid);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles, %0d reports outstanding",
                 $time, STALL_LIMIT, tick_reports_due.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int         phase;
        int         start_items;
        logic [7:0] setting;
        logic       first_row;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < OPENING_ROWS; i++)
            push_item(opening[i].item, opening[i].typed, opening[i].res);

        start_items = input_items;
        phase = 0;
        while (input_items - start_items < RANDOM_ITEMS) begin
            if (phase < PRESETS)
                setting = presets[phase];
            else
                setting = {3'($urandom_range(0, ($urandom_range(0, 5) == 0) ? 7 : 4)),
                           1'($urandom_range(0, 1)), 4'($urandom_range(0, 15))};
            // Spare data bits above the effect and pulse register widths must be ignored.
            write_setting(CFG_EFFECT, {1'($urandom_range(0, 1)), setting[7:5]});
            write_setting(CFG_PULSE, {3'($urandom_range(0, 7)), setting[4]});
            write_setting(CFG_LEVEL, setting[3:0]);
            if (phase == 0)
                write_setting(CFG_SPARE, 4'($urandom_range(0, 15)));
            if (phase == PRESSURE_PHASE)
                hold_pending = 1'b1;

            if (phase == 6 || phase == 14) begin
                chase_back_from_zero();
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 4) == 0) begin
                        // Noise: writes and ticks in no particular order.
                        repeat ($urandom_range(4, 16))
                            push_item({1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                       6'($urandom_range(0, 63))}, 1'b0, NO_REPORT);
                    end else begin
                        first_row = 1'($urandom_range(0, 1));
                        push_write(first_row, pick_length());
                        if ($urandom_range(0, 3) != 0)
                            push_write(!first_row, pick_length());
                        repeat ($urandom_range(10, 90)) begin
                            if ($urandom_range(0, 19) == 0)
                                push_write(1'($urandom_range(0, 1)), pick_length());
                            else
                                push_tick();
                        end
                    end
                end
            end
            phase++;
        end

        // A closing stretch of steady backlight at a nonzero level drawn from 1 to 15.
        write_setting(CFG_PULSE, 4'd0);
        write_setting(CFG_LEVEL, 4'($urandom_range(1, 15)));
        push_write(1'($urandom_range(0, 1)), pick_length());
        repeat (CLOSING_TICKS) push_tick();

        in_valid <= 1'b0;
        while (tick_reports_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d items, checked %0d tick reports over %0d register settings.",
                 input_items, reports_checked, phase);
        $display("Included a long receiver hold-off, back shifts from zero and steady levels;"
                 , " %0d field mismatches.", failures);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
